// ===== rtl/graph_bfs_dfs_traversal_assert.svh =====
// Assertion macros for the graph traversal block.
`ifndef GRAPH_BFS_DFS_TRAVERSAL_ASSERT_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GBDT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gbdt assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define GBDT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gbdt assertion failed");

`endif

// ===== rtl/gbdt_pkg.sv =====
// Package: sizes, codes and payload widths of the graph traversal block.
package gbdt_pkg;
	localparam int MAX_VERTICES = 64;
	localparam int MAX_EDGES    = 512;
	localparam int WORK_DEPTH   = 2 * MAX_EDGES;

	localparam int VTX_W = 6;
	localparam int CNT_W = 7;
	localparam int EI_W  = $clog2(MAX_EDGES);
	localparam int LK_W  = $clog2(MAX_EDGES + 1);
	localparam int WI_W  = $clog2(WORK_DEPTH);
	localparam int WP_W  = $clog2(WORK_DEPTH + 1);

	localparam logic [LK_W-1:0] NIL_LINK = LK_W'(MAX_EDGES);

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_BFS = 2'd1;
	localparam logic [1:0] CMD_DFS = 2'd2;

	localparam logic [1:0] ST_VISIT     = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_OUT_RANGE = 2'd2;
endpackage

// ===== rtl/gbdt_if.sv =====
// Interfaces: request, result and configuration channels.
interface gbdt_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [5:0] from_vertex;
	logic [5:0] to_vertex;
	logic [5:0] start_vertex;
	modport source (output valid, cmd, from_vertex, to_vertex, start_vertex, input ready);
	modport sink (input valid, cmd, from_vertex, to_vertex, start_vertex, output ready);
endinterface

interface gbdt_rsp_if;
	logic       valid;
	logic       ready;
	logic [5:0] vertex;
	logic       last;
	logic [1:0] status;
	modport source (output valid, vertex, last, status, input ready);
	modport sink (input valid, vertex, last, status, output ready);
endinterface

interface gbdt_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== rtl/graph_bfs_dfs_traversal.sv =====
// Directed graph store with breadth-first and depth-first traversal. The
// graph lives in adjacency lists held in synchronous RAMs: a per-vertex head
// and tail memory, and an edge store of target and link memories that are
// read together, one edge per cycle. A 1024-entry work RAM serves as the FIFO
// for breadth-first and as the stack for depth-first walks; the seen marks and
// the per-vertex list valid bits are flip-flops that reset clears at once, so
// there is no clearing pass after reset. An add-edge item writes the target
// and a terminating link while reading the tail, then does the link fixup. A
// traversal pops work entries, visits each, and scans its list through the
// single read port of the edge store; a visit waits while the result channel
// is stalled. Results stream out as they are found, each visit held back in
// a pending register so that the final one carries last.
// The vertex_count register saturates at 64 and may be written only while idle.
module graph_bfs_dfs_traversal (
	input  logic clk,
	input  logic arst_n,
	gbdt_cfg_if.sink   cfg,
	gbdt_req_if.sink   req,
	gbdt_rsp_if.source rsp
);
	`include "graph_bfs_dfs_traversal_assert.svh"

	typedef enum logic [3:0] {
		S_IDLE, S_STAT, S_ADD_A, S_ADD_B, S_START, S_POP, S_POPW,
		S_VISIT, S_HEAD, S_EDGE, S_FLUSH
	} state_t;

	state_t state_q;

	logic [gbdt_pkg::CNT_W-1:0] vc_q;
	logic [gbdt_pkg::CNT_W-1:0] cnt;
	logic [1:0]                 cmd_q;
	logic [gbdt_pkg::VTX_W-1:0] from_q, to_q, start_q, v_q;
	logic [1:0]                 stat_q;
	logic [gbdt_pkg::LK_W-1:0]  edges_q;
	logic [gbdt_pkg::WP_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [gbdt_pkg::MAX_VERTICES-1:0] seen_q, lvalid_q;
	logic                       pend_valid_q;
	logic [gbdt_pkg::VTX_W-1:0] pend_q;
	logic                       out_valid_q, out_last_q;
	logic [gbdt_pkg::VTX_W-1:0] out_vtx_q;
	logic [1:0]                 out_stat_q;

	// RAM ports
	logic                       head_we, tail_we, tgt_we, link_we, work_we;
	logic [gbdt_pkg::VTX_W-1:0] head_raddr;
	logic [gbdt_pkg::LK_W-1:0]  head_rdata, tail_rdata, link_rdata, link_wdata;
	logic [gbdt_pkg::EI_W-1:0]  edge_raddr, link_waddr;
	logic [gbdt_pkg::VTX_W-1:0] tgt_rdata, work_rdata, work_wdata;
	logic [gbdt_pkg::WI_W-1:0]  work_waddr, work_raddr;

	logic bfs, can_emit, emit, stall, push_ok, q_empty, in_bad, vtx_bad, out_load;

	assign cnt = (vc_q > gbdt_pkg::CNT_W'(gbdt_pkg::MAX_VERTICES))
		? gbdt_pkg::CNT_W'(gbdt_pkg::MAX_VERTICES) : vc_q;
	assign bfs      = (cmd_q == gbdt_pkg::CMD_BFS);
	assign can_emit = !out_valid_q || rsp.ready;

	// Range checks on the incoming item.
	assign vtx_bad = ({1'b0, req.start_vertex} >= cnt);
	assign in_bad  = ({1'b0, req.from_vertex} >= cnt) || ({1'b0, req.to_vertex} >= cnt);

	// Visit decision: BFS emits every dequeued vertex, DFS only unseen ones.
	assign emit  = bfs || !seen_q[v_q];
	assign stall = emit && pend_valid_q && !can_emit;

	// Result register load: status, a held-back visit, or the final visit.
	assign out_load = (((state_q == S_STAT) || (state_q == S_FLUSH)) && can_emit)
		|| ((state_q == S_VISIT) && !stall && emit && pend_valid_q);

	// Queue or stack empty.
	assign q_empty = bfs ? (rd_ptr_q == wr_ptr_q) : (wr_ptr_q == '0);

	// Neighbor push test: in range, unseen, room in the work store.
	assign push_ok = ({1'b0, tgt_rdata} < cnt) && !seen_q[tgt_rdata]
		&& (wr_ptr_q < gbdt_pkg::WP_W'(gbdt_pkg::WORK_DEPTH));

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid  = out_valid_q;
	assign rsp.vertex = out_vtx_q;
	assign rsp.last   = out_last_q;
	assign rsp.status = out_stat_q;

	always_comb begin
		head_we    = (state_q == S_ADD_A) && !lvalid_q[from_q];
		tail_we    = (state_q == S_ADD_B);
		tgt_we     = (state_q == S_ADD_A);
		head_raddr = v_q;
		// Link store: terminate the new edge, then chain it behind the old tail.
		link_we    = (state_q == S_ADD_A) || ((state_q == S_ADD_B) && lvalid_q[from_q]);
		link_waddr = (state_q == S_ADD_A) ? edges_q[gbdt_pkg::EI_W-1:0]
			: tail_rdata[gbdt_pkg::EI_W-1:0];
		link_wdata = (state_q == S_ADD_A) ? gbdt_pkg::NIL_LINK : edges_q;
		edge_raddr = (state_q == S_HEAD) ? head_rdata[gbdt_pkg::EI_W-1:0]
			: link_rdata[gbdt_pkg::EI_W-1:0];
		work_we    = (state_q == S_START) || ((state_q == S_EDGE) && push_ok);
		work_waddr = (state_q == S_START) ? '0 : wr_ptr_q[gbdt_pkg::WI_W-1:0];
		work_wdata = (state_q == S_START) ? start_q : tgt_rdata;
		work_raddr = bfs ? rd_ptr_q[gbdt_pkg::WI_W-1:0]
			: gbdt_pkg::WI_W'(wr_ptr_q - gbdt_pkg::WP_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			vc_q         <= gbdt_pkg::CNT_W'(64);
			edges_q      <= '0;
			seen_q       <= '0;
			lvalid_q     <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
		end else begin
			if (cfg.valid) begin
				vc_q <= cfg.data;
			end
			// Load the result register, or drop it once taken.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q   <= req.cmd;
						from_q  <= req.from_vertex;
						to_q    <= req.to_vertex;
						start_q <= req.start_vertex;
						priority if (req.cmd == gbdt_pkg::CMD_ADD) begin
							if (in_bad) begin
								stat_q  <= gbdt_pkg::ST_OUT_RANGE;
								state_q <= S_STAT;
							end else if (edges_q >= gbdt_pkg::LK_W'(gbdt_pkg::MAX_EDGES)) begin
								stat_q  <= gbdt_pkg::ST_FULL;
								state_q <= S_STAT;
							end else begin
								state_q <= S_ADD_A;
							end
						end else if (req.cmd == gbdt_pkg::CMD_BFS
							|| req.cmd == gbdt_pkg::CMD_DFS) begin
							if (vtx_bad) begin
								stat_q  <= gbdt_pkg::ST_OUT_RANGE;
								state_q <= S_STAT;
							end else begin
								seen_q  <= '0;
								state_q <= S_START;
							end
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_STAT: begin
					if (can_emit) begin
						out_vtx_q   <= '0;
						out_last_q  <= 1'b1;
						out_stat_q  <= stat_q;
						state_q     <= S_IDLE;
					end
				end
				S_ADD_A: begin
					state_q <= S_ADD_B;
				end
				S_ADD_B: begin
					lvalid_q[from_q] <= 1'b1;
					edges_q          <= edges_q + 1'b1;
					state_q          <= S_IDLE;
				end
				S_START: begin
					if (bfs) begin
						seen_q[start_q] <= 1'b1;
					end
					wr_ptr_q     <= gbdt_pkg::WP_W'(1);
					rd_ptr_q     <= '0;
					pend_valid_q <= 1'b0;
					state_q      <= S_POP;
				end
				S_POP: begin
					if (q_empty) begin
						state_q <= S_FLUSH;
					end else begin
						if (bfs) begin
							rd_ptr_q <= rd_ptr_q + 1'b1;
						end else begin
							wr_ptr_q <= wr_ptr_q - 1'b1;
						end
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					v_q     <= work_rdata;
					state_q <= S_VISIT;
				end
				S_VISIT: begin
					if (!stall) begin
						if (emit) begin
							if (pend_valid_q) begin
								out_vtx_q   <= pend_q;
								out_last_q  <= 1'b0;
								out_stat_q  <= gbdt_pkg::ST_VISIT;
							end
							pend_q       <= v_q;
							pend_valid_q <= 1'b1;
							seen_q[v_q]  <= 1'b1;
						end
						state_q <= lvalid_q[v_q] ? S_HEAD : S_POP;
					end
				end
				S_HEAD: begin
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					if (push_ok) begin
						wr_ptr_q <= wr_ptr_q + 1'b1;
						if (bfs) begin
							seen_q[tgt_rdata] <= 1'b1;
						end
					end
					if (link_rdata == gbdt_pkg::NIL_LINK) begin
						state_q <= S_POP;
					end
				end
				S_FLUSH: begin
					if (can_emit) begin
						out_vtx_q    <= pend_q;
						out_last_q   <= 1'b1;
						out_stat_q   <= gbdt_pkg::ST_VISIT;
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	gbdt_ram #(.WIDTH(gbdt_pkg::LK_W), .DEPTH(gbdt_pkg::MAX_VERTICES)) u_head (
		.clk(clk), .we(head_we), .waddr(from_q), .wdata(edges_q),
		.raddr(head_raddr), .rdata(head_rdata)
	);

	gbdt_ram #(.WIDTH(gbdt_pkg::LK_W), .DEPTH(gbdt_pkg::MAX_VERTICES)) u_tail (
		.clk(clk), .we(tail_we), .waddr(from_q), .wdata(edges_q),
		.raddr(from_q), .rdata(tail_rdata)
	);

	gbdt_ram #(.WIDTH(gbdt_pkg::VTX_W), .DEPTH(gbdt_pkg::MAX_EDGES)) u_tgt (
		.clk(clk), .we(tgt_we), .waddr(edges_q[gbdt_pkg::EI_W-1:0]), .wdata(to_q),
		.raddr(edge_raddr), .rdata(tgt_rdata)
	);

	gbdt_ram #(.WIDTH(gbdt_pkg::LK_W), .DEPTH(gbdt_pkg::MAX_EDGES)) u_link (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.raddr(edge_raddr), .rdata(link_rdata)
	);

	gbdt_ram #(.WIDTH(gbdt_pkg::VTX_W), .DEPTH(gbdt_pkg::WORK_DEPTH)) u_work (
		.clk(clk), .we(work_we), .waddr(work_waddr), .wdata(work_wdata),
		.raddr(work_raddr), .rdata(work_rdata)
	);

	`GBDT_ASSERT_NOW(a_edges_bound, 1'b1, edges_q <= gbdt_pkg::LK_W'(gbdt_pkg::MAX_EDGES))
	`GBDT_ASSERT_NOW(a_work_bound, 1'b1, wr_ptr_q <= gbdt_pkg::WP_W'(gbdt_pkg::WORK_DEPTH))
	`GBDT_ASSERT_NOW(a_flush_pend, state_q == S_FLUSH, pend_valid_q)
	`GBDT_ASSERT_NOW(a_fifo_order, bfs && state_q == S_POP, rd_ptr_q <= wr_ptr_q)
endmodule

// ===== rtl/gbdt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gbdt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== dv/graph_bfs_dfs_traversal_test.sv =====
// Testbench for the graph traversal block: predicted visit order against the block.
`timescale 1ns / 1ps

module graph_bfs_dfs_traversal_test;
	typedef struct packed {
		logic [gbdt_pkg::VTX_W-1:0] vertex;
		logic                       last;
		logic [1:0]                 status;
	} visit_t;

	localparam logic [1:0] CMD_NONE = 2'd3;
	// Cycles without any accepted item before the run is declared hung.
	localparam int IDLE_LIMIT = 200000;
	// Cycles to let an add-edge finish after the last result has come.
	localparam int SETTLE_CYCLES = 12;

	logic clk;
	logic arst_n;

	gbdt_cfg_if cfg ();
	gbdt_req_if req ();
	gbdt_rsp_if rsp ();

	graph_bfs_dfs_traversal u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg.sink),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// Predictor state: own copy of the graph, seen marks and work store.
	logic [gbdt_pkg::VTX_W-1:0] pred_target [gbdt_pkg::MAX_EDGES];
	int                         pred_link   [gbdt_pkg::MAX_EDGES];
	int                         pred_head   [gbdt_pkg::MAX_VERTICES];
	int                         pred_tail   [gbdt_pkg::MAX_VERTICES];
	int                         pred_edges;
	logic                       pred_seen   [gbdt_pkg::MAX_VERTICES];
	logic [gbdt_pkg::VTX_W-1:0] pred_work   [gbdt_pkg::WORK_DEPTH];
	logic [gbdt_pkg::CNT_W-1:0] pred_count;

	visit_t visit_q [$];
	int     error_count;
	int     idle_cycles = 0;
	int     burst_left;

	always #5 clk = ~clk;

	// Print one line per mismatch and count it.
	task automatic report(input string what);
		error_count++;
		$display("ERROR %0t: %s", $realtime, what);
	endtask

	// Append one expected result.
	function automatic void expect_add(input visit_t r);
		visit_q.insert(visit_q.size(), r);
	endfunction

	// Queue a single status result.
	function automatic void push_status(input logic [1:0] code);
		visit_t r;
		r.vertex = '0;
		r.last   = 1'b1;
		r.status = code;
		expect_add(r);
	endfunction

	// Work out the results one accepted request causes and update the graph.
	function automatic void predict_visits(input logic [1:0] cmd, input logic [5:0] fv,
			input logic [5:0] tv, input logic [5:0] sv);
		int     cnt;
		int     e;
		int     head;
		int     tail;
		int     n;
		int     first;
		logic [5:0] v;
		logic [5:0] u;
		visit_t r;
		cnt = (pred_count > gbdt_pkg::MAX_VERTICES) ? gbdt_pkg::MAX_VERTICES : int'(pred_count);
		n = 0;
		first = visit_q.size();
		if (cmd == CMD_NONE)
			return;
		if (cmd == gbdt_pkg::CMD_ADD) begin
			if (fv >= cnt || tv >= cnt) begin
				push_status(gbdt_pkg::ST_OUT_RANGE);
				return;
			end
			if (pred_edges >= gbdt_pkg::MAX_EDGES) begin
				push_status(gbdt_pkg::ST_FULL);
				return;
			end
			e = pred_edges++;
			pred_target[e] = tv;
			pred_link[e] = gbdt_pkg::MAX_EDGES;
			if (pred_head[fv] == gbdt_pkg::MAX_EDGES)
				pred_head[fv] = e;
			else
				pred_link[pred_tail[fv]] = e;
			pred_tail[fv] = e;
			return;
		end
		if (sv >= cnt) begin
			push_status(gbdt_pkg::ST_OUT_RANGE);
			return;
		end
		foreach (pred_seen[i])
			pred_seen[i] = 1'b0;
		r.last = 1'b0;
		r.status = gbdt_pkg::ST_VISIT;
		if (cmd == gbdt_pkg::CMD_BFS) begin
			// FIFO walk: mark on enqueue.
			head = 0;
			tail = 0;
			pred_seen[sv] = 1'b1;
			pred_work[tail++] = sv;
			while (head < tail) begin
				v = pred_work[head++];
				r.vertex = v;
				expect_add(r);
				n++;
				for (e = pred_head[v]; e != gbdt_pkg::MAX_EDGES; e = pred_link[e]) begin
					u = pred_target[e];
					if (u < cnt && !pred_seen[u] && tail < gbdt_pkg::WORK_DEPTH) begin
						pred_seen[u] = 1'b1;
						pred_work[tail++] = u;
					end
				end
			end
		end else begin
			// Stack walk: mark on pop, scan neighbors even of a seen vertex.
			tail = 0;
			pred_work[tail++] = sv;
			while (tail > 0) begin
				v = pred_work[--tail];
				if (!pred_seen[v]) begin
					if (n < gbdt_pkg::MAX_VERTICES) begin
						r.vertex = v;
						expect_add(r);
						n++;
					end
					pred_seen[v] = 1'b1;
				end
				for (e = pred_head[v]; e != gbdt_pkg::MAX_EDGES; e = pred_link[e]) begin
					u = pred_target[e];
					if (u < cnt && !pred_seen[u] && tail < gbdt_pkg::WORK_DEPTH)
						pred_work[tail++] = u;
				end
			end
		end
		visit_q[first + n - 1].last = 1'b1;
	endfunction

	// Send one request item, in bursts with random gaps between them.
	task automatic send_request(input logic [1:0] cmd, input logic [5:0] fv,
			input logic [5:0] tv, input logic [5:0] sv);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid        <= 1'b1;
		req.cmd          <= cmd;
		req.from_vertex  <= fv;
		req.to_vertex    <= tv;
		req.start_vertex <= sv;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		predict_visits(cmd, fv, tv, sv);
	endtask

	// Drop valid and wait until every expected result has arrived, then settle.
	task automatic drain();
		req.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (visit_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write vertex_count while the block is idle.
	task automatic write_count(input logic [gbdt_pkg::CNT_W-1:0] value);
		drain();
		cfg.valid <= 1'b1;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		pred_count = value;
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Pick a vertex mostly inside the current count, now and then anywhere.
	function automatic logic [5:0] pick_vertex();
		int cnt;
		cnt = (pred_count > gbdt_pkg::MAX_VERTICES) ? gbdt_pkg::MAX_VERTICES : int'(pred_count);
		if (cnt == 0 || $urandom_range(0, 19) == 0)
			return 6'($urandom_range(0, 63));
		return 6'($urandom_range(0, cnt - 1));
	endfunction

	// Small graph: every command, both walks, out of range, unused command.
	task automatic test_directed();
		write_count(7'd8);
		send_request(gbdt_pkg::CMD_ADD, 6'd0, 6'd1, 6'd0);
		send_request(gbdt_pkg::CMD_ADD, 6'd0, 6'd2, 6'd0);
		send_request(gbdt_pkg::CMD_ADD, 6'd1, 6'd3, 6'd0);
		send_request(gbdt_pkg::CMD_ADD, 6'd2, 6'd3, 6'd0);
		send_request(gbdt_pkg::CMD_ADD, 6'd3, 6'd0, 6'd0);
		send_request(gbdt_pkg::CMD_ADD, 6'd3, 6'd7, 6'd0);
		send_request(gbdt_pkg::CMD_ADD, 6'd7, 6'd7, 6'd0);
		send_request(gbdt_pkg::CMD_BFS, 6'd0, 6'd0, 6'd0);
		send_request(gbdt_pkg::CMD_DFS, 6'd0, 6'd0, 6'd0);
		send_request(gbdt_pkg::CMD_DFS, 6'd63, 6'd63, 6'd7);
		send_request(gbdt_pkg::CMD_BFS, 6'd0, 6'd0, 6'd5);
		send_request(gbdt_pkg::CMD_ADD, 6'd8, 6'd0, 6'd0);
		send_request(gbdt_pkg::CMD_ADD, 6'd0, 6'd63, 6'd0);
		send_request(gbdt_pkg::CMD_BFS, 6'd0, 6'd0, 6'd8);
		send_request(gbdt_pkg::CMD_DFS, 6'd0, 6'd0, 6'd63);
		send_request(CMD_NONE, 6'd63, 6'd63, 6'd63);
		// Full range: vertex 63 is now legal.
		write_count(7'd64);
		send_request(gbdt_pkg::CMD_ADD, 6'd63, 6'd0, 6'd0);
		send_request(gbdt_pkg::CMD_ADD, 6'd7, 6'd63, 6'd0);
		send_request(gbdt_pkg::CMD_DFS, 6'd0, 6'd0, 6'd63);
		send_request(gbdt_pkg::CMD_BFS, 6'd0, 6'd0, 6'd0);
	endtask

	// Count zero rejects everything, counts above 64 saturate, edges go stale.
	task automatic test_count_extremes();
		write_count(7'd0);
		send_request(gbdt_pkg::CMD_ADD, 6'd0, 6'd0, 6'd0);
		send_request(gbdt_pkg::CMD_BFS, 6'd0, 6'd0, 6'd0);
		send_request(gbdt_pkg::CMD_DFS, 6'd0, 6'd0, 6'd0);
		write_count(7'd127);
		send_request(gbdt_pkg::CMD_BFS, 6'd0, 6'd0, 6'd63);
		send_request(gbdt_pkg::CMD_DFS, 6'd0, 6'd0, 6'd3);
		write_count(7'd1);
		send_request(gbdt_pkg::CMD_ADD, 6'd0, 6'd0, 6'd0);
		send_request(gbdt_pkg::CMD_BFS, 6'd0, 6'd0, 6'd0);
		send_request(gbdt_pkg::CMD_DFS, 6'd0, 6'd0, 6'd0);
		// Count 4: edges into 7 and 63 are skipped.
		write_count(7'd4);
		send_request(gbdt_pkg::CMD_BFS, 6'd0, 6'd0, 6'd0);
		send_request(gbdt_pkg::CMD_DFS, 6'd0, 6'd0, 6'd3);
	endtask

	// Random phases under several counts, adds weighted to grow the graph.
	task automatic test_random();
		int phase;
		int k;
		int pick;
		logic [1:0] cmd;
		logic [6:0] counts [6];
		counts = '{7'd12, 7'd64, 7'd5, 7'd30, 7'd2, 7'd100};
		for (phase = 0; phase < 6; phase++) begin
			write_count(counts[phase]);
			for (k = 0; k < 20; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					cmd = gbdt_pkg::CMD_ADD;
				else if (pick < 76)
					cmd = gbdt_pkg::CMD_BFS;
				else if (pick < 97)
					cmd = gbdt_pkg::CMD_DFS;
				else
					cmd = CMD_NONE;
				send_request(cmd, pick_vertex(), pick_vertex(), pick_vertex());
			end
		end
	endtask

	// Fill the edge store, then check full, range-before-full, and big walks.
	task automatic test_store_full();
		write_count(7'd64);
		while (pred_edges < gbdt_pkg::MAX_EDGES)
			send_request(gbdt_pkg::CMD_ADD, 6'($urandom_range(0, 63)),
				6'($urandom_range(0, 63)), 6'd0);
		send_request(gbdt_pkg::CMD_ADD, 6'd0, 6'd1, 6'd0);
		send_request(gbdt_pkg::CMD_ADD, 6'd63, 6'd63, 6'd0);
		write_count(7'd40);
		send_request(gbdt_pkg::CMD_ADD, 6'd45, 6'd0, 6'd0);
		send_request(gbdt_pkg::CMD_ADD, 6'd1, 6'd2, 6'd0);
		send_request(gbdt_pkg::CMD_BFS, 6'd0, 6'd0, 6'd0);
		write_count(7'd64);
		send_request(gbdt_pkg::CMD_DFS, 6'd0, 6'd0, 6'd0);
		send_request(gbdt_pkg::CMD_BFS, 6'd0, 6'd0, 6'd63);
		send_request(gbdt_pkg::CMD_DFS, 6'd0, 6'd0, 6'd63);
	endtask

	// Receiver: stall pattern changes mode every so often.
	int stall_mode = 0;
	int mode_cycles = 0;
	always @(posedge clk) begin
		if (mode_cycles == 0) begin
			stall_mode  <= $urandom_range(0, 2);
			mode_cycles <= $urandom_range(50, 400);
		end else begin
			mode_cycles <= mode_cycles - 1;
		end
		case (stall_mode)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= ($urandom_range(0, 9) < 7);
			default: rsp.ready <= ((mode_cycles % 8) < 3);
		endcase
	end

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		visit_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (visit_q.size() == 0) begin
				report($sformatf("unexpected result vertex %0d last %0b status %0d",
					rsp.vertex, rsp.last, rsp.status));
			end else begin
				want = visit_q.pop_front();
				if (rsp.vertex !== want.vertex)
					report($sformatf("vertex %0d, want %0d", rsp.vertex, want.vertex));
				if (rsp.last !== want.last)
					report($sformatf("last %0b, want %0b (vertex %0d)",
						rsp.last, want.last, want.vertex));
				if (rsp.status !== want.status)
					report($sformatf("status %0d, want %0d", rsp.status, want.status));
			end
		end
	end

	// Watchdog: count cycles in which no item moves on any channel.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("graph_bfs_dfs_traversal: mismatch");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = gbdt_pkg::CMD_ADD;
		req.from_vertex = '0;
		req.to_vertex = '0;
		req.start_vertex = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		error_count = 0;
		burst_left = 0;
		// Mirror the block's reset state.
		foreach (pred_head[i]) begin
			pred_head[i] = gbdt_pkg::MAX_EDGES;
			pred_tail[i] = gbdt_pkg::MAX_EDGES;
			pred_seen[i] = 1'b0;
		end
		pred_edges = 0;
		pred_count = 7'd64;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_count_extremes();
		test_random();
		test_store_full();

		drain();
		repeat (20) @(posedge clk);
		if (visit_q.size() != 0)
			report($sformatf("%0d results never arrived", visit_q.size()));
		if (error_count == 0)
			$display("graph_bfs_dfs_traversal: match");
		else
			$display("graph_bfs_dfs_traversal: mismatch");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/gbdt_pkg.sv
rtl/gbdt_if.sv
rtl/gbdt_ram.sv
rtl/graph_bfs_dfs_traversal.sv
dv/graph_bfs_dfs_traversal_test.sv
